>>> design/gf16_minmax_layered_ldpc_decoder_defines.svh
// Assertion macros for the GF(16) min-max layered decoder.
// Used by the top level; expects clk and rst_n in scope.
`ifndef GF16_MINMAX_LAYERED_LDPC_DECODER_DEFINES_SVH
`define GF16_MINMAX_LAYERED_LDPC_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define GMM_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmm assertion failed");

// Next-cycle implication, disabled during reset
`define GMM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmm assertion failed");

`endif

>>> design/gmm_pkg.sv
// Shared types, constants and GF(16) tables for the min-max layered decoder.
// No dependencies; used by the interfaces and all modules.
package gmm_pkg;

    localparam int QSYM            = 16;
    localparam int DEG             = 4;
    localparam int DEF_NUM_COLUMNS = 32;
    localparam int DEF_NUM_ROWS    = 16;
    localparam int DEF_LLR_BITS    = 12;
    localparam int COL_IN_W        = 5;
    localparam int ROW_IN_W        = 4;
    localparam int LLR_IN_W        = 11;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_ROW   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_DIFF,
        ST_NORM,
        ST_CONV_A,
        ST_CONV_B,
        ST_CONV_C,
        ST_WR,
        ST_DEC
    } state_t;

    typedef struct packed {
        op_t                 operation;
        logic [3:0]          row_index;
        logic [4:0]          column_a;
        logic [4:0]          column_b;
        logic [4:0]          column_c;
        logic [4:0]          column_d;
        logic [3:0]          coef_a;
        logic [3:0]          coef_b;
        logic [3:0]          coef_c;
        logic [3:0]          coef_d;
        logic [3:0]          symbol;
        logic [10:0]         llr_value;
    } in_item_t;

    typedef struct packed {
        logic [4:0]          column;
        logic [3:0]          decided_symbol;
        logic [10:0]         min_llr;
    } out_item_t;

    // GF(16) addition table, symbol indices in power representation
    localparam logic [3:0] GF_ADD [QSYM][QSYM] = '{
        '{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
        '{4'd1,4'd0,4'd5,4'd9,4'd15,4'd2,4'd11,4'd14,4'd10,4'd3,4'd8,4'd6,4'd13,4'd12,4'd7,4'd4},
        '{4'd2,4'd5,4'd0,4'd6,4'd10,4'd1,4'd3,4'd12,4'd15,4'd11,4'd4,4'd9,4'd7,4'd14,4'd13,4'd8},
        '{4'd3,4'd9,4'd6,4'd0,4'd7,4'd11,4'd2,4'd4,4'd13,4'd1,4'd12,4'd5,4'd10,4'd8,4'd15,4'd14},
        '{4'd4,4'd15,4'd10,4'd7,4'd0,4'd8,4'd12,4'd3,4'd5,4'd14,4'd2,4'd13,4'd6,4'd11,4'd9,4'd1},
        '{4'd5,4'd2,4'd1,4'd11,4'd8,4'd0,4'd9,4'd13,4'd4,4'd6,4'd15,4'd3,4'd14,4'd7,4'd12,4'd10},
        '{4'd6,4'd11,4'd3,4'd2,4'd12,4'd9,4'd0,4'd10,4'd14,4'd5,4'd7,4'd1,4'd4,4'd15,4'd8,4'd13},
        '{4'd7,4'd14,4'd12,4'd4,4'd3,4'd13,4'd10,4'd0,4'd11,4'd15,4'd6,4'd8,4'd2,4'd5,4'd1,4'd9},
        '{4'd8,4'd10,4'd15,4'd13,4'd5,4'd4,4'd14,4'd11,4'd0,4'd12,4'd1,4'd7,4'd9,4'd3,4'd6,4'd2},
        '{4'd9,4'd3,4'd11,4'd1,4'd14,4'd6,4'd5,4'd15,4'd12,4'd0,4'd13,4'd2,4'd8,4'd10,4'd4,4'd7},
        '{4'd10,4'd8,4'd4,4'd12,4'd2,4'd15,4'd7,4'd6,4'd1,4'd13,4'd0,4'd14,4'd3,4'd9,4'd11,4'd5},
        '{4'd11,4'd6,4'd9,4'd5,4'd13,4'd3,4'd1,4'd8,4'd7,4'd2,4'd14,4'd0,4'd15,4'd4,4'd10,4'd12},
        '{4'd12,4'd13,4'd7,4'd10,4'd6,4'd14,4'd4,4'd2,4'd9,4'd8,4'd3,4'd15,4'd0,4'd1,4'd5,4'd11},
        '{4'd13,4'd12,4'd14,4'd8,4'd11,4'd7,4'd15,4'd5,4'd3,4'd10,4'd9,4'd4,4'd1,4'd0,4'd2,4'd6},
        '{4'd14,4'd7,4'd13,4'd15,4'd9,4'd12,4'd8,4'd1,4'd6,4'd4,4'd11,4'd10,4'd5,4'd2,4'd0,4'd3},
        '{4'd15,4'd4,4'd8,4'd14,4'd1,4'd10,4'd13,4'd9,4'd2,4'd7,4'd5,4'd12,4'd11,4'd6,4'd3,4'd0}
    };

    // Source symbol for lane k of a cyclic shift over the nonzero symbols.
    // Forward shifts down by sh, inverse shifts up; symbol zero stays put.
    function automatic logic [3:0] perm_src(input logic [3:0] k, input logic [3:0] sh,
                                           input logic inv);
        logic [4:0] t;
        begin
            if (inv)
                t = {1'b0, k} - 5'd1 + {1'b0, sh};
            else
                t = {1'b0, k} + 5'd14 - {1'b0, sh};
            if (t >= 5'd15)
                t = t - 5'd15;
            return (k == 4'd0) ? 4'd0 : (t[3:0] + 4'd1);
        end
    endfunction

endpackage

>>> design/gmm_if.sv
// Valid/ready stream interfaces for decoder requests and decision results.
// Depends on gmm_pkg for the payload types.
interface gmm_in_if;
    import gmm_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gmm_out_if;
    import gmm_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/gf16_minmax_layered_ldpc_decoder.sv
// Layered GF(16) min-max LDPC decoder, check degree 4. Column LLR vectors sit in
// one memory (a 16-symbol word per column, lane write mask) and check messages in a
// second (a 16-symbol word per row and edge); both have registered reads.
// A load is written as the request is taken. A decision read takes the request, then
// searches the minimum into the output register once that register is free. A clear
// takes the request, then sweeps the check memory one word a cycle; the sweep also
// runs after reset before the first request is taken. A row takes the request, then
// reads, subtracts and normalizes each edge in turn, runs the six convolutions on
// two min-max units that each produce one symbol a cycle, and writes back messages
// and columns edge by edge. One request is in flight at a time; a
// finished decision waits in an output register while the next request is taken.
// Depends on gmm_pkg, gmm_if and gmm_minmax.
module gf16_minmax_layered_ldpc_decoder #(
    parameter int NUM_COLUMNS = gmm_pkg::DEF_NUM_COLUMNS,
    parameter int NUM_ROWS    = gmm_pkg::DEF_NUM_ROWS,
    parameter int LLR_BITS    = gmm_pkg::DEF_LLR_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    gmm_in_if.sink     request,
    gmm_out_if.source  result
);
    import gmm_pkg::*;
    `include "gf16_minmax_layered_ldpc_decoder_defines.svh"

    localparam int VAL_W     = LLR_BITS - 1;
    localparam int LLR_MAX   = (1 << VAL_W) - 1;
    localparam int COL_W     = $clog2(NUM_COLUMNS);
    localparam int ROW_W     = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int CHK_AW    = ROW_W + 2;
    localparam int CHK_DEPTH = NUM_ROWS * DEG;

    // Wrap tables for out-of-range indices
    logic [COL_W-1:0] col_wrap [1 << COL_IN_W];
    logic [ROW_W-1:0] row_wrap [1 << ROW_IN_W];

    for (genvar g = 0; g < (1 << COL_IN_W); g++)
    begin : g_col_wrap
        assign col_wrap[g] = COL_W'(g % NUM_COLUMNS);
    end
    for (genvar g = 0; g < (1 << ROW_IN_W); g++)
    begin : g_row_wrap
        assign row_wrap[g] = ROW_W'(g % NUM_ROWS);
    end

    // Memories and their read data registers
    logic [VAL_W-1:0] llr_mem [NUM_COLUMNS][QSYM];
    logic [VAL_W-1:0] chk_mem [CHK_DEPTH][QSYM];
    logic [VAL_W-1:0] llr_rd_reg [QSYM];
    logic [VAL_W-1:0] chk_rd_reg [QSYM];

    // Control state
    state_t            state_reg, state_next;
    logic [1:0]        edge_reg, edge_next;
    logic [3:0]        lane_reg, lane_next;
    logic [CHK_AW-1:0] clr_reg, clr_next;
    logic              out_valid_reg, out_valid_next;

    // Request fields held for the duration of the work
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg [DEG];
    logic [3:0]        sh_reg [DEG];
    logic [4:0]        col_in_reg;
    logic [4:0]        col_out_reg;

    // Working vectors
    logic signed [VAL_W:0] diff_reg [QSYM];
    logic [VAL_W-1:0]  q_reg [DEG][QSYM];
    logic [VAL_W-1:0]  f1_reg [QSYM];
    logic [VAL_W-1:0]  b2_reg [QSYM];
    logic [VAL_W-1:0]  f2_reg [QSYM];
    logic [VAL_W-1:0]  b1_reg [QSYM];
    logic [VAL_W-1:0]  r1_reg [QSYM];
    logic [VAL_W-1:0]  r2_reg [QSYM];

    // Output register
    logic [3:0]        out_sym_reg;
    logic [VAL_W-1:0]  out_min_reg;

    logic              accept;
    logic              dec_load;

    // Memory port controls
    logic              llr_re, llr_we, chk_re, chk_we;
    logic [COL_W-1:0]  llr_raddr, llr_waddr;
    logic [QSYM-1:0]   llr_wmask;
    logic [VAL_W-1:0]  llr_wdata [QSYM];
    logic [CHK_AW-1:0] chk_raddr, chk_waddr;
    logic [VAL_W-1:0]  chk_wdata [QSYM];

    // Datapath combinational values
    logic signed [VAL_W:0] diff_next [QSYM];
    logic [VAL_W-1:0]  qn [QSYM];
    logic [VAL_W-1:0]  r_sel [QSYM];
    logic [VAL_W-1:0]  v_sum [QSYM];
    logic [VAL_W-1:0]  load_val;
    logic [VAL_W-1:0]  mm0_x [QSYM];
    logic [VAL_W-1:0]  mm0_y [QSYM];
    logic [VAL_W-1:0]  mm1_x [QSYM];
    logic [VAL_W-1:0]  mm1_y [QSYM];
    logic [VAL_W-1:0]  mm0_res, mm1_res;
    logic [3:0]        am_sym;
    logic [VAL_W-1:0]  am_val;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign dec_load      = (state_reg == ST_DEC) && (!out_valid_reg || result.ready);

    // Saturate a loaded value to the stored range
    assign load_val = (32'(request.data.llr_value) > LLR_MAX) ? {VAL_W{1'b1}}
                                                               : VAL_W'(request.data.llr_value);

    // Next state and counters
    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        lane_next  = lane_reg;
        clr_next   = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CHK_AW'(CHK_DEPTH - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                edge_next = 2'd0;
                lane_next = 4'd0;
                clr_next  = '0;
                if (accept)
                begin
                    unique case (request.data.operation)
                        OP_LOAD:  state_next = ST_IDLE;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_ROW:   state_next = ST_RD;
                        OP_READ:  state_next = ST_DEC;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD:   state_next = ST_DIFF;
            ST_DIFF: state_next = ST_NORM;
            ST_NORM:
            begin
                edge_next = edge_reg + 1'b1;
                state_next = (edge_reg == 2'd3) ? ST_CONV_A : ST_RD;
            end
            ST_CONV_A, ST_CONV_B, ST_CONV_C:
            begin
                lane_next = lane_reg + 1'b1;
                if (lane_reg == 4'd15)
                begin
                    unique case (state_reg)
                        ST_CONV_A: state_next = ST_CONV_B;
                        ST_CONV_B: state_next = ST_CONV_C;
                        default:   state_next = ST_WR;
                    endcase
                end
            end
            ST_WR:
            begin
                edge_next = edge_reg + 1'b1;
                if (edge_reg == 2'd3)
                    state_next = ST_IDLE;
            end
            ST_DEC:
            begin
                if (dec_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Memory port controls
    always_comb
    begin
        llr_re    = 1'b0;
        llr_raddr = col_reg[edge_reg];
        llr_we    = 1'b0;
        llr_waddr = col_reg[edge_reg];
        llr_wmask = '1;
        llr_wdata = v_sum;
        chk_re    = 1'b0;
        chk_raddr = {row_reg, edge_reg};
        chk_we    = 1'b0;
        chk_waddr = {row_reg, edge_reg};
        chk_wdata = r_sel;
        unique case (state_reg)
            ST_CLEAR:
            begin
                chk_we    = 1'b1;
                chk_waddr = clr_reg;
                for (int k = 0; k < QSYM; k++)
                    chk_wdata[k] = '0;
            end
            ST_IDLE:
            begin
                llr_raddr = col_wrap[request.data.column_a];
                llr_waddr = col_wrap[request.data.column_a];
                llr_re    = accept && (request.data.operation == OP_READ);
                llr_we    = accept && (request.data.operation == OP_LOAD);
                llr_wmask = QSYM'(1) << request.data.symbol;
                for (int k = 0; k < QSYM; k++)
                    llr_wdata[k] = load_val;
            end
            ST_RD:
            begin
                llr_re = 1'b1;
                chk_re = 1'b1;
            end
            ST_WR:
            begin
                llr_we = 1'b1;
                chk_we = 1'b1;
            end
            default:
            begin
                llr_re = 1'b0;
            end
        endcase
    end

    // Memory arrays: lane-masked write of the column memory, registered reads
    always_ff @(posedge clk)
    begin
        if (llr_we)
        begin
            for (int k = 0; k < QSYM; k++)
                if (llr_wmask[k])
                    llr_mem[llr_waddr][k] <= llr_wdata[k];
        end
        if (llr_re)
            llr_rd_reg <= llr_mem[llr_raddr];
        if (chk_we)
            chk_mem[chk_waddr] <= chk_wdata;
        if (chk_re)
            chk_rd_reg <= chk_mem[chk_raddr];
    end

    // Shift the column into edge order and subtract the stored message
    always_comb
    begin
        for (int k = 0; k < QSYM; k++)
            diff_next[k] = $signed({1'b0, llr_rd_reg[perm_src(4'(k), sh_reg[edge_reg], 1'b0)]})
                         - $signed({1'b0, chk_rd_reg[k]});
    end

    // Normalize to the minimum and saturate
    logic signed [VAL_W:0]   nm1 [8];
    logic signed [VAL_W:0]   nm2 [4];
    logic signed [VAL_W:0]   nm3 [2];
    logic signed [VAL_W:0]   nmin;
    logic signed [VAL_W+1:0] nt [QSYM];
    always_comb
    begin
        for (int j = 0; j < 8; j++)
            nm1[j] = (diff_reg[2*j+1] < diff_reg[2*j]) ? diff_reg[2*j+1] : diff_reg[2*j];
        for (int j = 0; j < 4; j++)
            nm2[j] = (nm1[2*j+1] < nm1[2*j]) ? nm1[2*j+1] : nm1[2*j];
        for (int j = 0; j < 2; j++)
            nm3[j] = (nm2[2*j+1] < nm2[2*j]) ? nm2[2*j+1] : nm2[2*j];
        nmin = (nm3[1] < nm3[0]) ? nm3[1] : nm3[0];
        for (int k = 0; k < QSYM; k++)
        begin
            nt[k] = (VAL_W+2)'(diff_reg[k]) - (VAL_W+2)'(nmin);
            qn[k] = (nt[k][VAL_W+1:VAL_W] != 2'b00) ? {VAL_W{1'b1}} : nt[k][VAL_W-1:0];
        end
    end

    // Select the operands of the two convolution units
    always_comb
    begin
        mm0_x = q_reg[0];
        mm0_y = q_reg[1];
        mm1_x = q_reg[3];
        mm1_y = q_reg[2];
        priority case (state_reg)
            ST_CONV_B:
            begin
                mm0_x = f1_reg;
                mm0_y = q_reg[2];
                mm1_x = b2_reg;
                mm1_y = q_reg[1];
            end
            ST_CONV_C:
            begin
                mm0_x = q_reg[0];
                mm0_y = b2_reg;
                mm1_x = f1_reg;
                mm1_y = q_reg[3];
            end
            default:
            begin
                mm0_x = q_reg[0];
            end
        endcase
    end

    gmm_minmax #(.VAL_W(VAL_W)) u_mm0 (
        .x    (mm0_x),
        .y    (mm0_y),
        .lane (lane_reg),
        .res  (mm0_res)
    );

    gmm_minmax #(.VAL_W(VAL_W)) u_mm1 (
        .x    (mm1_x),
        .y    (mm1_y),
        .lane (lane_reg),
        .res  (mm1_res)
    );

    // New message of the current edge, added back and shifted home
    logic [VAL_W:0] sm [QSYM];
    logic [VAL_W-1:0] vv [QSYM];
    always_comb
    begin
        unique case (edge_reg)
            2'd0:    r_sel = b1_reg;
            2'd1:    r_sel = r1_reg;
            2'd2:    r_sel = r2_reg;
            default: r_sel = f2_reg;
        endcase
        for (int k = 0; k < QSYM; k++)
        begin
            sm[k] = {1'b0, r_sel[k]} + {1'b0, q_reg[edge_reg][k]};
            vv[k] = sm[k][VAL_W] ? {VAL_W{1'b1}} : sm[k][VAL_W-1:0];
        end
        for (int k = 0; k < QSYM; k++)
            v_sum[k] = vv[perm_src(4'(k), sh_reg[edge_reg], 1'b1)];
    end

    // First minimum over the decision column
    logic [VAL_W-1:0] av1 [8];
    logic [3:0]       ai1 [8];
    logic [VAL_W-1:0] av2 [4];
    logic [3:0]       ai2 [4];
    logic [VAL_W-1:0] av3 [2];
    logic [3:0]       ai3 [2];
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if (llr_rd_reg[2*j+1] < llr_rd_reg[2*j])
            begin
                av1[j] = llr_rd_reg[2*j+1];
                ai1[j] = 4'(2*j+1);
            end
            else
            begin
                av1[j] = llr_rd_reg[2*j];
                ai1[j] = 4'(2*j);
            end
        end
        for (int j = 0; j < 4; j++)
        begin
            av2[j] = (av1[2*j+1] < av1[2*j]) ? av1[2*j+1] : av1[2*j];
            ai2[j] = (av1[2*j+1] < av1[2*j]) ? ai1[2*j+1] : ai1[2*j];
        end
        for (int j = 0; j < 2; j++)
        begin
            av3[j] = (av2[2*j+1] < av2[2*j]) ? av2[2*j+1] : av2[2*j];
            ai3[j] = (av2[2*j+1] < av2[2*j]) ? ai2[2*j+1] : ai2[2*j];
        end
        am_val = (av3[1] < av3[0]) ? av3[1] : av3[0];
        am_sym = (av3[1] < av3[0]) ? ai3[1] : ai3[0];
    end

    assign out_valid_next = dec_load ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            edge_reg      <= 2'd0;
            lane_reg      <= 4'd0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            edge_reg      <= edge_next;
            lane_reg      <= lane_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold request fields and working vectors
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg     <= row_wrap[request.data.row_index];
            col_reg[0]  <= col_wrap[request.data.column_a];
            col_reg[1]  <= col_wrap[request.data.column_b];
            col_reg[2]  <= col_wrap[request.data.column_c];
            col_reg[3]  <= col_wrap[request.data.column_d];
            sh_reg[0]   <= (request.data.coef_a == 4'd15) ? 4'd0 : request.data.coef_a;
            sh_reg[1]   <= (request.data.coef_b == 4'd15) ? 4'd0 : request.data.coef_b;
            sh_reg[2]   <= (request.data.coef_c == 4'd15) ? 4'd0 : request.data.coef_c;
            sh_reg[3]   <= (request.data.coef_d == 4'd15) ? 4'd0 : request.data.coef_d;
            col_in_reg  <= request.data.column_a;
        end
        if (state_reg == ST_DIFF)
            diff_reg <= diff_next;
        if (state_reg == ST_NORM)
            q_reg[edge_reg] <= qn;
        if (state_reg == ST_CONV_A)
        begin
            f1_reg[lane_reg] <= mm0_res;
            b2_reg[lane_reg] <= mm1_res;
        end
        if (state_reg == ST_CONV_B)
        begin
            f2_reg[lane_reg] <= mm0_res;
            b1_reg[lane_reg] <= mm1_res;
        end
        if (state_reg == ST_CONV_C)
        begin
            r1_reg[lane_reg] <= mm0_res;
            r2_reg[lane_reg] <= mm1_res;
        end
        if (dec_load)
        begin
            col_out_reg <= col_in_reg;
            out_sym_reg <= am_sym;
            out_min_reg <= am_val;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.data.column         = col_out_reg;
    assign result.data.decided_symbol = out_sym_reg;
    assign result.data.min_llr        = LLR_IN_W'(out_min_reg);

    // A result appears only out of the decision state
    `GMM_ASSERT_IMPLY(a_out_from_dec, $rose(out_valid_reg), $past(state_reg) == ST_DEC)
    // Check messages are written only by the clearing sweep or the write-back
    `GMM_ASSERT_IMPLY(a_chk_write_src, chk_we, (state_reg == ST_WR) || (state_reg == ST_CLEAR))
    // The last edge's normalize starts the first convolution at symbol zero
    `GMM_ASSERT_NEXT(a_norm_to_conv, (state_reg == ST_NORM) && (edge_reg == 2'd3),
                     (state_reg == ST_CONV_A) && (lane_reg == 4'd0))

endmodule

>>> design/gmm_minmax.sv
// One output symbol of a GF(16) min-max convolution per cycle.
// Depends on gmm_pkg for the addition table.
module gmm_minmax #(
    parameter int VAL_W = gmm_pkg::DEF_LLR_BITS - 1
) (
    input  logic [VAL_W-1:0] x [gmm_pkg::QSYM],
    input  logic [VAL_W-1:0] y [gmm_pkg::QSYM],
    input  logic [3:0]       lane,
    output logic [VAL_W-1:0] res
);
    import gmm_pkg::*;

    logic [VAL_W-1:0] mx [QSYM];
    logic [VAL_W-1:0] l1 [8];
    logic [VAL_W-1:0] l2 [4];
    logic [VAL_W-1:0] l3 [2];

    // Pair each x term with its partner in y and take the larger
    always_comb
    begin
        for (int k = 0; k < QSYM; k++)
        begin
            mx[k] = (x[k] > y[GF_ADD[k][lane]]) ? x[k] : y[GF_ADD[k][lane]];
        end
    end

    // Reduce to the minimum with a four-level tree
    always_comb
    begin
        for (int j = 0; j < 8; j++)
            l1[j] = (mx[2*j+1] < mx[2*j]) ? mx[2*j+1] : mx[2*j];
        for (int j = 0; j < 4; j++)
            l2[j] = (l1[2*j+1] < l1[2*j]) ? l1[2*j+1] : l1[2*j];
        for (int j = 0; j < 2; j++)
            l3[j] = (l2[2*j+1] < l2[2*j]) ? l2[2*j+1] : l2[2*j];
        res = (l3[1] < l3[0]) ? l3[1] : l3[0];
    end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the GF(16) min-max layered LDPC decoder.
// Needs gmm_pkg, gmm_if and the decoder RTL; drives random codeword sessions.
`timescale 1ns / 100ps

module tb_top;
    import gmm_pkg::*;

    localparam int NCOL = 32;
    localparam int NROW = 16;
    localparam int LMAX = 2047;

    // Decoder state mirror: predicts decisions from the accepted requests
    class decision_board;
        int        llr_mem [NCOL][QSYM];
        int        msg_mem [NROW][DEG][QSYM];
        out_item_t pending_decisions [$];
        int        errors;
        int        n_load, n_clear, n_row, n_read, n_checked;

        function int clip(int v);
            if (v < 0) return 0;
            return (v > LMAX) ? LMAX : v;
        endfunction

        // res[i] = min over k of max(x[k], y[k + i]) in GF(16)
        function void gf_minmax(input int x[QSYM], input int y[QSYM], output int res[QSYM]);
            int best, m, yv;
            for (int i = 0; i < QSYM; i++)
            begin
                best = 0;
                for (int k = 0; k < QSYM; k++)
                begin
                    yv = y[GF_ADD[k][i]];
                    m = (x[k] > yv) ? x[k] : yv;
                    if (k == 0 || m < best) best = m;
                end
                res[i] = best;
            end
        endfunction

        function void run_row(int row, int cols[DEG], int shifts[DEG]);
            int q [DEG][QSYM];
            int r [DEG][QSYM];
            int f1[QSYM], f2[QSYM], b1[QSYM], b2[QSYM], v[QSYM];
            int mn, s;
            // Gather all columns before any write-back
            for (int e = 0; e < DEG; e++)
            begin
                mn = 0;
                for (int k = 0; k < QSYM; k++)
                begin
                    s = (k == 0) ? 0 : ((k - 1 + 15 - shifts[e]) % 15) + 1;
                    q[e][k] = llr_mem[cols[e]][s] - msg_mem[row][e][k];
                    if (k == 0 || q[e][k] < mn) mn = q[e][k];
                end
                for (int k = 0; k < QSYM; k++) q[e][k] = clip(q[e][k] - mn);
            end
            gf_minmax(q[0], q[1], f1);
            gf_minmax(f1, q[2], f2);
            gf_minmax(q[3], q[2], b2);
            gf_minmax(b2, q[1], b1);
            r[0] = b1;
            gf_minmax(q[0], b2, r[1]);
            gf_minmax(f1, q[3], r[2]);
            r[3] = f2;
            // Write back in edge order; a repeated column keeps the later edge
            for (int e = 0; e < DEG; e++)
            begin
                for (int k = 0; k < QSYM; k++)
                begin
                    msg_mem[row][e][k] = r[e][k];
                    v[k] = clip(r[e][k] + q[e][k]);
                end
                for (int k = 0; k < QSYM; k++)
                begin
                    s = (k == 0) ? 0 : ((k - 1 + shifts[e]) % 15) + 1;
                    llr_mem[cols[e]][k] = v[s];
                end
            end
        endfunction

        function void note_request(in_item_t it);
            int cols[DEG], shifts[DEG];
            int best;
            out_item_t d;
            cols   = '{int'(it.column_a), int'(it.column_b), int'(it.column_c),
                       int'(it.column_d)};
            shifts = '{it.coef_a % 15, it.coef_b % 15, it.coef_c % 15, it.coef_d % 15};
            case (it.operation)
                OP_LOAD:
                begin
                    llr_mem[it.column_a][it.symbol] = int'(it.llr_value);
                    n_load++;
                end
                OP_CLEAR:
                begin
                    foreach (msg_mem[a, b, c]) msg_mem[a][b][c] = 0;
                    n_clear++;
                end
                OP_ROW:
                begin
                    run_row(int'(it.row_index), cols, shifts);
                    n_row++;
                end
                default:
                begin
                    best = 0;
                    for (int k = 1; k < QSYM; k++)
                        if (llr_mem[it.column_a][k] < llr_mem[it.column_a][best]) best = k;
                    d.column         = it.column_a;
                    d.decided_symbol = 4'(best);
                    d.min_llr        = 11'(llr_mem[it.column_a][best]);
                    pending_decisions.push_back(d);
                    n_read++;
                end
            endcase
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_d;
            if (pending_decisions.size() == 0)
            begin
                $display("%0t: unexpected decision col=%0d sym=%0d llr=%0d", $time,
                         got.column, got.decided_symbol, got.min_llr);
                errors++;
                return;
            end
            exp_d = pending_decisions.pop_front();
            n_checked++;
            if (got.column != exp_d.column)
            begin
                $display("%0t: column mismatch exp=%0d got=%0d", $time, exp_d.column, got.column);
                errors++;
            end
            if (got.decided_symbol != exp_d.decided_symbol)
            begin
                $display("%0t: symbol mismatch col=%0d exp=%0d got=%0d", $time, exp_d.column,
                         exp_d.decided_symbol, got.decided_symbol);
                errors++;
            end
            if (got.min_llr != exp_d.min_llr)
            begin
                $display("%0t: min llr mismatch col=%0d exp=%0d got=%0d", $time, exp_d.column,
                         exp_d.min_llr, got.min_llr);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    gmm_in_if  req_if ();
    gmm_out_if res_if ();

    gf16_minmax_layered_ldpc_decoder uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_if),
        .result  (res_if)
    );

    decision_board board;
    bit [QSYM-1:0] loaded [NCOL];
    int burst_left;
    int sent;
    int rx_cycle;
    bit paused;

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watch both channels; every accepted request updates the mirror
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready) board.note_request(req_if.data);
            if (res_if.valid && res_if.ready) board.check_result(res_if.data);
        end
    end

    // Receiver stalls: phases of always-ready, coin-flip, sparse and rare-stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_cycle      <= 0;
            res_if.ready  <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            case ((rx_cycle / 300) % 4)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= (rx_cycle % 7 == 0);
                default: res_if.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function in_item_t noise_fields();
        in_item_t it;
        it = in_item_t'($bits(in_item_t)'({$urandom, $urandom}));
        return it;
    endfunction

    // Hand one request over, idling before most bursts; valid stays high inside a burst
    task send(in_item_t it);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sent++;
        if (it.operation == OP_LOAD) loaded[it.column_a][it.symbol] = 1'b1;
    endtask

    task load_entry(int col, int sym, int val);
        in_item_t it;
        it = noise_fields();
        it.operation = OP_LOAD;
        it.column_a  = 5'(col);
        it.symbol    = 4'(sym);
        it.llr_value = 11'(val);
        send(it);
    endtask

    task load_column(int col);
        for (int s = 0; s < QSYM; s++)
            load_entry(col, s, ($urandom_range(0, 9) == 0) ? LMAX : $urandom_range(0, 900));
    endtask

    task clear_store();
        in_item_t it;
        it = noise_fields();
        it.operation = OP_CLEAR;
        send(it);
    endtask

    task do_row(int row, int c0, int c1, int c2, int c3, int k0, int k1, int k2, int k3);
        in_item_t it;
        it = noise_fields();
        it.operation = OP_ROW;
        it.row_index = 4'(row);
        it.column_a = 5'(c0); it.column_b = 5'(c1); it.column_c = 5'(c2); it.column_d = 5'(c3);
        it.coef_a = 4'(k0); it.coef_b = 4'(k1); it.coef_c = 4'(k2); it.coef_d = 4'(k3);
        send(it);
    endtask

    task read_decision(int col);
        in_item_t it;
        it = noise_fields();
        it.operation = OP_READ;
        it.column_a  = 5'(col);
        send(it);
    endtask

    function bit full(int col);
        return &loaded[col];
    endfunction

    // One decoding session: bring columns in, optionally clear, run rows, read back
    task codeword_session();
        int set_cols[$];
        int ncols, c, e_cols[DEG];
        set_cols.delete();
        ncols = $urandom_range(4, 8);
        for (int i = 0; i < ncols; i++)
        begin
            c = $urandom_range(0, NCOL - 1);
            if (!full(c) && $urandom_range(0, 3) != 0)
            begin
                // prefer columns already loaded
                for (int j = 0; j < NCOL; j++)
                    if (full((c + j) % NCOL))
                    begin
                        c = (c + j) % NCOL;
                        break;
                    end
            end
            if (!full(c)) load_column(c);
            set_cols.push_back(c);
        end
        repeat ($urandom_range(0, 3))
            load_entry(set_cols[$urandom_range(0, ncols - 1)], $urandom_range(0, 15),
                       ($urandom_range(0, 4) == 0) ? LMAX : $urandom_range(0, LMAX));
        if ($urandom_range(0, 3) != 0) clear_store();
        repeat ($urandom_range(3, 8))
        begin
            foreach (e_cols[e]) e_cols[e] = set_cols[$urandom_range(0, ncols - 1)];
            do_row($urandom_range(0, NROW - 1), e_cols[0], e_cols[1], e_cols[2], e_cols[3],
                   $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 15));
            if ($urandom_range(0, 2) == 0) read_decision(set_cols[$urandom_range(0, ncols - 1)]);
        end
        repeat ($urandom_range(1, 4)) read_decision(set_cols[$urandom_range(0, ncols - 1)]);
    endtask

    // Noise: stray loads anywhere, reads of any fully loaded column, bare clears
    task noise_burst();
        int c;
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 2))
                0: load_entry($urandom_range(0, NCOL - 1), $urandom_range(0, 15),
                              $urandom_range(0, LMAX));
                1:
                begin
                    c = $urandom_range(0, NCOL - 1);
                    if (full(c)) read_decision(c);
                end
                default: clear_store();
            endcase
        end
    endtask

    // Drop the request and wait until every expected decision has come back
    task drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (board.pending_decisions.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        board      = new();
        burst_left = 0;
        sent       = 0;
        paused     = 1'b0;
        foreach (loaded[i]) loaded[i] = '0;
        rst_n = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Bring up four columns; column 0 gets all-zero, column 1 saturated values
        for (int s = 0; s < QSYM; s++) load_entry(0, s, 0);
        for (int s = 0; s < QSYM; s++) load_entry(1, s, LMAX);
        load_column(2);
        load_column(3);

        // Directed: ties, shift extremes, wrap-around coefficient, repeated columns
        read_decision(0);
        read_decision(1);
        do_row(0, 0, 1, 2, 3, 0, 0, 0, 0);
        do_row(NROW - 1, 3, 2, 1, 0, 14, 15, 1, 7);
        do_row(0, 0, 0, 1, 1, 15, 3, 14, 0);
        do_row(5, 2, 2, 2, 2, 1, 2, 3, 4);
        read_decision(0);
        read_decision(1);
        read_decision(2);
        read_decision(3);
        load_entry(3, 15, LMAX);
        load_entry(3, 0, 0);
        read_decision(3);
        clear_store();
        do_row(NROW - 1, 0, 1, 2, 3, 15, 15, 15, 15);
        read_decision(2);
        drain();

        // Random sessions, with one full pause midway
        while (sent < 950)
        begin
            if ($urandom_range(0, 4) == 0) noise_burst();
            else codeword_session();
            if (!paused && sent > 475)
            begin
                paused = 1'b1;
                drain();
                @(posedge clk);
            end
        end
        req_if.valid <= 1'b0;

        drain();
        repeat (200) @(posedge clk);
        $display("Covered %0d loads, %0d clears, %0d rows, %0d reads; %0d decisions checked.",
                 board.n_load, board.n_clear, board.n_row, board.n_read, board.n_checked);
        if (board.errors == 0 && board.pending_decisions.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #20ms;
        $display("Timeout with %0d decisions outstanding", board.pending_decisions.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/gmm_pkg.sv
design/gmm_if.sv
design/gmm_minmax.sv
design/gf16_minmax_layered_ldpc_decoder.sv
sim/tb_top.sv
